### sv/rnd_pkg.sv
// ----------------------------------------------------------------------------
// rnd_pkg
// Shared types and constants for the rectangle nest-or-disjoint filter.
// ----------------------------------------------------------------------------
package rnd_pkg;

  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_OUT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BOUND,
    ST_SCAN,
    ST_DONE
  } rnd_state_t;

endpackage

### sv/rectangle_nest_or_disjoint_filter_top.sv
// ----------------------------------------------------------------------------
// rectangle_nest_or_disjoint_filter_top
// Judges candidate rectangles against the board and a list of accepted ones.
// ----------------------------------------------------------------------------
// One request at a time. An accepted request passes through ST_BOUND, then
// ST_SCAN when there is a scan, then ST_DONE, and the next request is taken
// once its result has been loaded into the output register. The scan reads
// and compares one stored rectangle per cycle through a single compare unit,
// so its length grows with the number of rectangles already in the list; the
// longest scan is for a list one short of full. A full list, an empty list or
// a board failure skips the scan, and a failing compare ends the scan at that
// entry. A result waits in an output register, so a new request is taken
// while the previous result is still pending; the following result then waits
// in ST_DONE until out_ready frees the register.
module rectangle_nest_or_disjoint_filter_top
  import rnd_pkg::*;
#(
  parameter int MAX_RECTS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   first_of_set,
  input  logic [COORD_BITS-1:0]  col_start,
  input  logic [COORD_BITS-1:0]  row_start,
  input  logic [COORD_BITS-1:0]  height,
  input  logic [COORD_BITS-1:0]  width,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   accepted,
  output logic                   store_full,
  output logic [COUNT_OUT_W-1:0] accepted_count
);

  localparam int EW   = COORD_BITS + 2;                      // signed end coordinate
  localparam int CMPW = (EW > REG_W + 1) ? EW : REG_W + 1;   // board compare width
  localparam int CW   = $clog2(MAX_RECTS + 1);
  localparam int AW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int DW   = 2 * COORD_BITS + 2 * EW;

  rnd_state_t state, state_next;

  logic [REG_W-1:0]        board_rows, board_cols;
  logic [COORD_BITS-1:0]   cand_col, cand_row;
  logic signed [EW-1:0]    cand_ecol, cand_erow;
  logic signed [EW-1:0]    in_ecol, in_erow;
  logic [CW-1:0]           count, idx, idx_next;
  logic                    pass, pass_next;
  logic                    full_hit, full_hit_next;

  logic [DW-1:0]           mem [MAX_RECTS];
  logic [DW-1:0]           rd_data;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;

  logic                    in_take, out_load;
  logic                    board_ok, fits;

  logic [COORD_BITS-1:0]   o_col, o_row;
  logic signed [EW-1:0]    o_ecol, o_erow;
  logic signed [EW-1:0]    c_x0, c_y0, o_x0, o_y0;
  logic [CW-1:0]           count_inc;

  assign in_ready = (state == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);
  assign mem_we   = out_load && pass;
  assign count_inc = CW'(count + 1'b1);

  // end = start + span - 1; a zero span gives start - 1
  assign in_ecol = $signed(EW'(col_start) + EW'(width) - EW'(1));
  assign in_erow = $signed(EW'(row_start) + EW'(height) - EW'(1));

  assign board_ok = (CMPW'(cand_ecol) <= $signed(CMPW'(board_cols))) &&
                    (CMPW'(cand_erow) <= $signed(CMPW'(board_rows)));

  assign {o_col, o_row, o_ecol, o_erow} = rd_data;
  assign c_x0 = $signed(EW'(cand_col));
  assign c_y0 = $signed(EW'(cand_row));
  assign o_x0 = $signed(EW'(o_col));
  assign o_y0 = $signed(EW'(o_row));

  // inside, wholly after, or wholly before the stored rectangle
  assign fits = (c_x0 >= o_x0 && cand_ecol <= o_ecol &&
                 c_y0 >= o_y0 && cand_erow <= o_erow) ||
                (c_x0 > o_ecol || c_y0 > o_erow) ||
                (cand_ecol < o_x0 || cand_erow < o_y0);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    pass_next     = pass;
    full_hit_next = full_hit;
    rd_addr       = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_BOUND;
        end
      end
      ST_BOUND: begin
        full_hit_next = (count == CW'(MAX_RECTS));
        pass_next     = !full_hit_next && board_ok;
        idx_next      = CW'(1);
        if (!pass_next || count == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // rd_data holds entry idx - 1
        rd_addr = idx[AW-1:0];
        if (!fits) begin
          pass_next  = 1'b0;
          state_next = ST_DONE;
        end else if (idx == count) begin
          state_next = ST_DONE;
        end else begin
          idx_next = CW'(idx + 1'b1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      board_rows <= '1;
      board_cols <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOARD_ROWS: board_rows <= cfg_data;
        REG_BOARD_COLS: board_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pass     <= pass_next;
    full_hit <= full_hit_next;
    if (in_take) begin
      cand_col  <= col_start;
      cand_row  <= row_start;
      cand_ecol <= in_ecol;
      cand_erow <= in_erow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_take && first_of_set) begin
      count <= '0;
    end else if (mem_we) begin
      count <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= {cand_col, cand_row, cand_ecol, cand_erow};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted       <= pass;
      store_full     <= full_hit;
      accepted_count <= pass ? COUNT_OUT_W'(count_inc) : COUNT_OUT_W'(count);
    end
  end

`ifndef ASSERT_OFF
  a_excl_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && store_full))
    else $error("accepted and store_full both set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECTS))
    else $error("rectangle count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> count == $past(count_inc))
    else $error("count did not advance on store");

  a_take_start: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_BOUND)
    else $error("request accepted but check did not start");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives candidate rectangles through the nest-or-disjoint filter with random
// handshake gaps on both sides. Each result is checked against a cycle-free
// model of the accepted list and board limits. The run starts with a short
// table of corner cases, then random phases over several board settings.
// ----------------------------------------------------------------------------
module testbench;
  import rnd_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int MAX_HELD   = 64;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = MAX_HELD + 8;
  localparam int VERDICT_SLOTS = 8;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] height;
    logic [COORD_BITS-1:0] width;
  } rect_t;

  typedef struct packed {
    logic                   accepted;
    logic                   store_full;
    logic [COUNT_OUT_W-1:0] count;
  } verdict_t;

  typedef struct packed {
    logic                   fos;
    logic [COORD_BITS-1:0]  col;
    logic [COORD_BITS-1:0]  row;
    logic [COORD_BITS-1:0]  height;
    logic [COORD_BITS-1:0]  width;
    logic                   typed;
    logic                   acc;
    logic                   full;
    logic [COUNT_OUT_W-1:0] cnt;
  } table_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_BOARD_ROWS;
  logic [REG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   first_of_set = 1'b0;
  logic [COORD_BITS-1:0]  col_start = '0;
  logic [COORD_BITS-1:0]  row_start = '0;
  logic [COORD_BITS-1:0]  height = '0;
  logic [COORD_BITS-1:0]  width = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   accepted;
  logic                   store_full;
  logic [COUNT_OUT_W-1:0] accepted_count;

  // model state
  rect_t            held [MAX_HELD];
  int               held_count = 0;
  logic [REG_W-1:0] board_rows_m = 12'hFFF;
  logic [REG_W-1:0] board_cols_m = 12'hFFF;

  // expected results, in request order
  verdict_t   pending_verdicts [VERDICT_SLOTS];
  int         verdicts_sent = 0;
  int         verdicts_seen = 0;
  table_row_t corner_rows [15];
  int         error_count = 0;
  int         result_index = 0;
  int         stall_left = 0;
  logic       no_idle = 1'b0;

  rectangle_nest_or_disjoint_filter_top #(
    .MAX_RECTS  (MAX_HELD),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_of_set   (first_of_set),
    .col_start      (col_start),
    .row_start      (row_start),
    .height         (height),
    .width          (width),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .store_full     (store_full),
    .accepted_count (accepted_count)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic note_error(input string msg);
    if (error_count < 100) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic queue_verdict(input verdict_t v);
    pending_verdicts[verdicts_sent % VERDICT_SLOTS] = v;
    verdicts_sent++;
  endtask

  // mostly zero, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Judge one candidate against the board and the held list; updates the list.
  function automatic verdict_t judge_rect(input rect_t c, input logic fos);
    verdict_t v;
    logic     ok;
    int       i;
    int       cx0, cx1, cy0, cy1, ox0, ox1, oy0, oy1;
    v = '0;
    if (fos) held_count = 0;
    if (held_count >= MAX_HELD) begin
      v.store_full = 1'b1;
    end else begin
      cx0 = int'(c.col);
      cy0 = int'(c.row);
      cx1 = cx0 + int'(c.width) - 1;   // may be -1 for zero size
      cy1 = cy0 + int'(c.height) - 1;
      ok = (cx1 <= int'(board_cols_m)) && (cy1 <= int'(board_rows_m));
      for (i = 0; ok && i < held_count; i++) begin
        ox0 = int'(held[i].col);
        oy0 = int'(held[i].row);
        ox1 = ox0 + int'(held[i].width) - 1;
        oy1 = oy0 + int'(held[i].height) - 1;
        ok = (cx0 >= ox0 && cx1 <= ox1 && cy0 >= oy0 && cy1 <= oy1) ||
             (cx0 > ox1 || cy0 > oy1) || (cx1 < ox0 || cy1 < oy0);
      end
      if (ok) begin
        held[held_count] = c;
        held_count++;
        v.accepted = 1'b1;
      end
    end
    v.count = COUNT_OUT_W'(held_count);
    return v;
  endfunction

  // random rectangle lying wholly inside o
  function automatic rect_t nest_in(input rect_t o);
    rect_t c;
    int    cw, ch, span;
    cw = $urandom_range(0, int'(o.width));
    span = int'(o.width) - cw;
    if (cw == 0 && span > 0) span--;
    c.width = COORD_BITS'(cw);
    c.col = COORD_BITS'(int'(o.col) + $urandom_range(0, span));
    ch = $urandom_range(0, int'(o.height));
    span = int'(o.height) - ch;
    if (ch == 0 && span > 0) span--;
    c.height = COORD_BITS'(ch);
    c.row = COORD_BITS'(int'(o.row) + $urandom_range(0, span));
    return c;
  endfunction

  task automatic write_board(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BOARD_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_BOARD_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    board_rows_m = rows;
    board_cols_m = cols;
  endtask

  task automatic send_candidate(input logic fos, input rect_t c, output verdict_t v);
    int gap;
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    first_of_set <= fos;
    col_start    <= c.col;
    row_start    <= c.row;
    height       <= c.height;
    width        <= c.width;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = judge_rect(c, fos);
  endtask

  task automatic drain();
    while (verdicts_seen != verdicts_sent) @(posedge clk);
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    int g;
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = idle_gap();
      if (no_idle || g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= g - 1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdicts_seen == verdicts_sent) begin
        note_error($sformatf("result %0d with no request outstanding", result_index));
      end else begin
        want = pending_verdicts[verdicts_seen % VERDICT_SLOTS];
        verdicts_seen++;
        if (accepted !== want.accepted)
          note_error($sformatf("result %0d accepted %b, want %b",
                               result_index, accepted, want.accepted));
        if (store_full !== want.store_full)
          note_error($sformatf("result %0d store_full %b, want %b",
                               result_index, store_full, want.store_full));
        if (accepted_count !== want.count)
          note_error($sformatf("result %0d accepted_count %0d, want %0d",
                               result_index, accepted_count, want.count));
      end
      result_index++;
    end
  end

  initial begin
    verdict_t   v;
    rect_t      cand;
    logic       fos;
    logic       fill;
    int         k, phase, sel, lim, pos;
    int         n_items, fos_pct, random_sent;
    int         rows_v, cols_v;

    // board stays at its reset size for the table
    corner_rows = '{
      '{1'b1, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 1'b1, 1'b0, 7'd1},
      // board check on the first of a set
      '{1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b0, 1'b0, 7'd0},
      '{1'b1, 12'd4095, 12'd4095, 12'd1,    12'd1,    1'b1, 1'b1, 1'b0, 7'd1},
      '{1'b0, 12'd4095, 12'd4095, 12'd1,    12'd1,    1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'd4094, 12'd4095, 12'd1,    12'd2,    1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b1, 12'd0,    12'd0,    12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0, 7'd1},
      '{1'b0, 12'd10,   12'd10,   12'd20,   12'd20,   1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'd25,   12'd25,   12'd10,   12'd10,   1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'd40,   12'd40,   12'd5,    12'd5,    1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'd1,    12'd0,    12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, 7'd0},
      // zero size: end coordinate is start - 1
      '{1'b0, 12'd15,   12'd15,   12'd0,    12'd0,    1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'd0,    12'd100,  12'd5,    12'd0,    1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'd0,    12'd4095, 12'd2,    12'd1,    1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'd4095, 12'd0,    12'd1,    12'd2,    1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, 12'hAAA,  12'h555,  12'h555,  12'h555,  1'b0, 1'b0, 1'b0, 7'd0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_rows[i]) begin
      cand = '{corner_rows[i].col, corner_rows[i].row,
               corner_rows[i].height, corner_rows[i].width};
      send_candidate(corner_rows[i].fos, cand, v);
      if (corner_rows[i].typed)
        v = '{corner_rows[i].acc, corner_rows[i].full, corner_rows[i].cnt};
      queue_verdict(v);
    end
    in_valid <= 1'b0;
    drain();

    random_sent = 0;
    for (phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
      case (phase % 6)
        0: begin rows_v = 4095; cols_v = 4095; end
        1: begin rows_v = 0; cols_v = 0; end
        2: begin rows_v = $urandom_range(0, 4095); cols_v = $urandom_range(0, 4095); end
        3: begin rows_v = 0; cols_v = 4095; end
        4: begin rows_v = 4095; cols_v = 0; end
        default: begin rows_v = $urandom_range(0, 300); cols_v = $urandom_range(0, 300); end
      endcase
      repeat (2) @(posedge clk);
      write_board(REG_W'(rows_v), REG_W'(cols_v));
      no_idle <= (phase % 4 == 3);
      fos_pct = $urandom_range(1, 10);
      if (phase % 6 == 1 || phase % 6 == 3 || phase % 6 == 4) n_items = 50;
      else n_items = $urandom_range(100, 180);
      if (n_items > RANDOM_ITEMS - random_sent) n_items = RANDOM_ITEMS - random_sent;

      for (k = 0; k < n_items; k++) begin
        // phase 0 starts by filling the list to the top, then hits it when full
        fill = (phase % 6 == 0) && (k < 72);
        if (fill) begin
          fos = (k == 0);
          sel = (held_count >= MAX_HELD && k > 0) ? 99 : 0;
        end else begin
          fos = (k == 0) || ($urandom_range(0, 99) < fos_pct);
          sel = $urandom_range(0, 99);
        end
        if (sel >= 85) begin
          cand.col    = COORD_BITS'($urandom_range(0, 4095));
          cand.row    = COORD_BITS'($urandom_range(0, 4095));
          cand.height = COORD_BITS'($urandom_range(0, 4095));
          cand.width  = COORD_BITS'($urandom_range(0, 4095));
        end else if (fos || held_count == 0 || sel >= 60) begin
          // fits the board, often small
          pos = $urandom_range(0, int'(board_cols_m));
          lim = int'(board_cols_m) - pos + 1;
          if (lim > 4095) lim = 4095;
          if ($urandom_range(0, 1) == 1 && lim > 64) lim = 64;
          cand.col   = COORD_BITS'(pos);
          cand.width = COORD_BITS'($urandom_range(0, lim));
          pos = $urandom_range(0, int'(board_rows_m));
          lim = int'(board_rows_m) - pos + 1;
          if (lim > 4095) lim = 4095;
          if ($urandom_range(0, 1) == 1 && lim > 64) lim = 64;
          cand.row    = COORD_BITS'(pos);
          cand.height = COORD_BITS'($urandom_range(0, lim));
        end else if (sel < 45) begin
          cand = nest_in(held[held_count-1]);  // always fits the whole list
        end else begin
          cand = nest_in(held[$urandom_range(0, held_count - 1)]);
        end
        send_candidate(fos, cand, v);
        queue_verdict(v);
        random_sent++;
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/rnd_pkg.sv
sv/rectangle_nest_or_disjoint_filter_top.sv
test/testbench.sv
